// ----- hdl/lmd_pkg.sv -----
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types, constants and functions of the 3x3 local minimum detector.
// ----------------------------------------------------------------------------
package lmd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int OUT_W     = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // result slots of one beat, in emission order
  localparam int SLOT_UP_LEFT  = 0;
  localparam int SLOT_UP       = 1;
  localparam int SLOT_CUR_LEFT = 2;
  localparam int SLOT_CUR      = 3;
  localparam int N_SLOTS       = 4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;  // [row][col], col 2 newest

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [N_SLOTS-1:0] en;
    logic [N_SLOTS-1:0] minimum;
  } bundle_t;

  // last index of a dimension: zero acts as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_last(logic [DIM_W-1:0] v, int maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv - 1);
    end else begin
      res = v - DIM_W'(1);
    end
    return res;
  endfunction

  // strict minimum of cell (wr, wc) against in-frame neighbors
  function automatic logic judge(win_t w, int wr, int wc,
                                 logic [2:0] row_ok, logic [2:0] col_ok);
    logic res;
    res = 1'b1;
    for (int tr = 0; tr < 3; tr++) begin
      for (int tc = 0; tc < 3; tc++) begin
        if (tr >= wr - 1 && tr <= wr + 1 && tc >= wc - 1 && tc <= wc + 1 &&
            !(tr == wr && tc == wc) && row_ok[tr] && col_ok[tc] &&
            w[wr][wc] >= w[tr][tc]) begin
          res = 1'b0;
        end
      end
    end
    return res;
  endfunction

endpackage

// ----- hdl/lmd_line_store.sv -----
// ----------------------------------------------------------------------------
// lmd_line_store
// Two line memories (one and two rows above), read in the cycle before the
// write back, with forwarding when a read hits the entry being written.
// ----------------------------------------------------------------------------
module lmd_line_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [lmd_pkg::COL_W-1:0] rd_addr,
  input  logic                      wr_en,
  input  logic [lmd_pkg::COL_W-1:0] wr_addr,
  input  lmd_pkg::pix_t             wr_prev,
  input  lmd_pkg::pix_t             wr_older,
  output lmd_pkg::pix_t             up1,
  output lmd_pkg::pix_t             up2
);

  lmd_pkg::pix_t prev_mem  [lmd_pkg::MAX_WIDTH];
  lmd_pkg::pix_t older_mem [lmd_pkg::MAX_WIDTH];

  lmd_pkg::pix_t prev_q;
  lmd_pkg::pix_t older_q;
  logic          fwd_hit;
  lmd_pkg::pix_t fwd_prev;
  lmd_pkg::pix_t fwd_older;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr]  <= wr_prev;
      older_mem[wr_addr] <= wr_older;
    end
    if (rd_en) begin
      prev_q  <= prev_mem[rd_addr];
      older_q <= older_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_prev  <= wr_prev;
      fwd_older <= wr_older;
    end
  end

  assign up1 = fwd_hit ? fwd_prev  : prev_q;
  assign up2 = fwd_hit ? fwd_older : older_q;

endmodule

// ----- hdl/lmd_window.sv -----
// ----------------------------------------------------------------------------
// lmd_window
// 3x3 window register; shifts in one column per beat and judges the up to
// four pixels resolved by the newest one.
// ----------------------------------------------------------------------------
module lmd_window (
  input  logic                      clk,
  input  logic                      rst,
  input  lmd_pkg::pos_t             pos,
  input  lmd_pkg::pix_t             px,
  input  lmd_pkg::pix_t             up1,
  input  lmd_pkg::pix_t             up2,
  input  logic [lmd_pkg::COL_W-1:0] width_last,
  input  logic [lmd_pkg::ROW_W-1:0] height_last,
  output logic                      push,
  output lmd_pkg::bundle_t          bundle
);

  lmd_pkg::win_t win;
  lmd_pkg::win_t win_next;
  logic [2:0]    row_ok;
  logic [2:0]    col_ok;
  logic          row_any;
  logic          col_any;
  logic          row_end;
  logic          col_end;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = up2;
    win_next[1][2] = up1;
    win_next[2][2] = px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (pos.valid) begin
      win <= win_next;
    end
  end

  assign row_any = (pos.row != '0);
  assign col_any = (pos.col != '0);
  assign row_end = (pos.row == height_last);
  assign col_end = (pos.col == width_last);
  assign row_ok  = {1'b1, row_any, pos.row > lmd_pkg::ROW_W'(1)};
  assign col_ok  = {1'b1, col_any, pos.col > lmd_pkg::COL_W'(1)};

  always_comb begin
    bundle.row = pos.row;
    bundle.col = pos.col;
    bundle.en[lmd_pkg::SLOT_UP_LEFT]  = row_any && col_any;
    bundle.en[lmd_pkg::SLOT_UP]       = row_any && col_end;
    bundle.en[lmd_pkg::SLOT_CUR_LEFT] = row_end && col_any;
    bundle.en[lmd_pkg::SLOT_CUR]      = row_end && col_end;
    bundle.minimum[lmd_pkg::SLOT_UP_LEFT]  = lmd_pkg::judge(win_next, 1, 1, row_ok, col_ok);
    bundle.minimum[lmd_pkg::SLOT_UP]       = lmd_pkg::judge(win_next, 1, 2, row_ok, col_ok);
    bundle.minimum[lmd_pkg::SLOT_CUR_LEFT] = lmd_pkg::judge(win_next, 2, 1, row_ok, col_ok);
    bundle.minimum[lmd_pkg::SLOT_CUR]      = lmd_pkg::judge(win_next, 2, 2, row_ok, col_ok);
  end

  assign push = pos.valid && (bundle.en != '0);

endmodule

// ----- hdl/lmd_result_queue.sv -----
// ----------------------------------------------------------------------------
// lmd_result_queue
// Queue of resolved bundles; the head is sent out one result per beat.
// ----------------------------------------------------------------------------
module lmd_result_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  lmd_pkg::bundle_t           bundle,
  output logic [lmd_pkg::QCNT_W-1:0] count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lmd_pkg::OUT_W-1:0]  pixel_row,
  output logic [lmd_pkg::OUT_W-1:0]  pixel_col,
  output logic                       is_minimum,
  output logic                       last_of_run
);

  lmd_pkg::bundle_t            q [lmd_pkg::QUEUE_DEPTH];
  logic [lmd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [lmd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [lmd_pkg::QCNT_W-1:0]  count_next;
  logic [lmd_pkg::N_SLOTS-1:0] done;
  logic [lmd_pkg::N_SLOTS-1:0] pending;
  logic [lmd_pkg::N_SLOTS-1:0] sel_mask;
  logic [1:0]                  sel;
  logic                        pop;
  lmd_pkg::bundle_t            head;
  logic [lmd_pkg::ROW_W-1:0]   row_sel;
  logic [lmd_pkg::COL_W-1:0]   col_sel;

  assign head    = q[rd_ptr];
  assign pending = head.en & ~done;

  always_comb begin
    sel = 2'd0;
    for (int i = lmd_pkg::N_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign sel_mask    = lmd_pkg::N_SLOTS'(1) << sel;
  assign out_valid   = (count != '0);
  assign last_of_run = ((pending & ~sel_mask) == '0);
  assign pop         = out_valid && out_ready && last_of_run;
  assign row_sel     = sel[1] ? head.row : head.row - lmd_pkg::ROW_W'(1);
  assign col_sel     = sel[0] ? head.col : head.col - lmd_pkg::COL_W'(1);
  assign pixel_row   = lmd_pkg::OUT_W'(row_sel);
  assign pixel_col   = lmd_pkg::OUT_W'(col_sel);
  assign is_minimum  = head.minimum[sel];
  assign count_next  = count + lmd_pkg::QCNT_W'(push) - lmd_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      done   <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + lmd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lmd_pkg::QPTR_W'(1);
        done   <= '0;
      end else if (out_valid && out_ready) begin
        done <= done | sel_mask;
      end
    end
  end

endmodule

// ----- hdl/local_minimum_detector_3x3_core.sv -----
// ----------------------------------------------------------------------------
// local_minimum_detector_3x3_core
// Strict 3x3 local minimum detection over a raster pixel stream.
//
//   channel  signals                                   role
//   in       in_valid/in_ready, pixel_blue             one pixel per beat
//   out      out_valid/out_ready, pixel_row, pixel_col, one result per beat
//            is_minimum, last_of_run
//   cfg      cfg_we, cfg_index, cfg_data               register write
//
// A pixel is taken every cycle while the result queue has room; a pixel
// with n results holds the output for n beats, so the rate follows the
// output side. Each pixel passes the s1 register before its results are queued.
// The line memories are read in the cycle before the write back, with a
// bypass when a read hits the entry being written. No clearing pass after reset.
// Output stalls back up through the four-entry result queue to in_ready.
// ----------------------------------------------------------------------------
module local_minimum_detector_3x3_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lmd_pkg::PIX_W-1:0]     pixel_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lmd_pkg::OUT_W-1:0]     pixel_row,
  output logic [lmd_pkg::OUT_W-1:0]     pixel_col,
  output logic                          is_minimum,
  output logic                          last_of_run,
  input  logic                          cfg_we,
  input  logic [lmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmd_pkg::DIM_W-1:0]     cfg_data
);

  logic [lmd_pkg::COL_W-1:0]  width_last;
  logic [lmd_pkg::ROW_W-1:0]  height_last;
  logic [lmd_pkg::COL_W-1:0]  col;
  logic [lmd_pkg::ROW_W-1:0]  row;
  logic [lmd_pkg::COL_W-1:0]  col_next;
  logic [lmd_pkg::ROW_W-1:0]  row_next;
  lmd_pkg::pos_t              s1;
  lmd_pkg::pix_t              s1_px;
  lmd_pkg::pix_t              up1;
  lmd_pkg::pix_t              up2;
  logic                       in_fire;
  logic                       push;
  lmd_pkg::bundle_t           bundle;
  logic [lmd_pkg::QCNT_W-1:0] q_count;
  logic [lmd_pkg::QCNT_W:0]   in_flight;

  assign in_flight = (lmd_pkg::QCNT_W+1)'(q_count) + (lmd_pkg::QCNT_W+1)'(s1.valid);
  assign in_ready  = in_flight < (lmd_pkg::QCNT_W+1)'(lmd_pkg::QUEUE_DEPTH);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    col_next = col + lmd_pkg::COL_W'(1);
    row_next = row;
    if (col == width_last) begin
      col_next = '0;
      row_next = (row == height_last) ? '0 : row + lmd_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= lmd_pkg::COL_W'(639);
      height_last <= lmd_pkg::ROW_W'(479);
      col         <= '0;
      row         <= '0;
      s1.valid    <= 1'b0;
    end else begin
      s1.valid <= in_fire;
      if (cfg_we) begin
        unique case (cfg_index)
          lmd_pkg::REG_FRAME_WIDTH: begin
            width_last <= lmd_pkg::COL_W'(lmd_pkg::clamp_last(cfg_data, lmd_pkg::MAX_WIDTH));
          end
          lmd_pkg::REG_FRAME_HEIGHT: begin
            height_last <= lmd_pkg::ROW_W'(lmd_pkg::clamp_last(cfg_data, lmd_pkg::MAX_HEIGHT));
          end
          default: ;
        endcase
        col <= '0;
        row <= '0;
      end else if (in_fire) begin
        col <= col_next;
        row <= row_next;
      end
    end
    if (in_fire) begin
      s1.row <= row;
      s1.col <= col;
      s1_px  <= pixel_blue;
    end
  end

  lmd_line_store u_line_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire),
    .rd_addr  (col),
    .wr_en    (s1.valid),
    .wr_addr  (s1.col),
    .wr_prev  (s1_px),
    .wr_older (up1),
    .up1      (up1),
    .up2      (up2)
  );

  lmd_window u_window (
    .clk         (clk),
    .rst         (rst),
    .pos         (s1),
    .px          (s1_px),
    .up1         (up1),
    .up2         (up2),
    .width_last  (width_last),
    .height_last (height_last),
    .push        (push),
    .bundle      (bundle)
  );

  lmd_result_queue u_result_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .bundle      (bundle),
    .count       (q_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .is_minimum  (is_minimum),
    .last_of_run (last_of_run)
  );

endmodule

// ----- hdl/lmd_checker.sv -----
// ----------------------------------------------------------------------------
// lmd_checker
// Port-level checks of the local minimum detector, bound to the top level.
// ----------------------------------------------------------------------------
module lmd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lmd_pkg::OUT_W-1:0]     pixel_row,
  input logic [lmd_pkg::OUT_W-1:0]     pixel_col,
  input logic                          is_minimum,
  input logic                          last_of_run
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("run broken before its last beat");

  a_run_rows_ascend: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> pixel_row >= $past(pixel_row))
    else $error("row went back within a run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_row) &&
      $stable(pixel_col) && $stable(is_minimum) && $stable(last_of_run))
    else $error("stalled result changed");

endmodule

bind local_minimum_detector_3x3_core lmd_checker u_lmd_checker (.*);
